### hw/rtl/xcfe_pkg.sv
// xcfe_pkg: shared types and constants of the xor checked frame extractor
// no dependencies; imported by xor_checked_frame_extractor_top

package xcfe_pkg;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_HUNT    = 5'b00001,
        ST_LEN     = 5'b00010,
        ST_PAYLOAD = 5'b00100,
        ST_CHECK   = 5'b01000,
        ST_REPLAY  = 5'b10000
    } t_state;

    localparam logic [7:0] START_MARKER_RST = 8'h55;
    localparam logic [7:0] LEN_MIN          = 8'd2;
    localparam logic [7:0] LEN_OVERHEAD     = 8'd3;

    localparam int FIELD_BYTES = 4;
    localparam int CNT_W       = 3;
    localparam int MAX_RESULTS = 63;
    localparam int RES_W       = 6;

    // byte0..byte3 and byte_count, padded to whole bytes
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

endpackage

### hw/rtl/xor_checked_frame_extractor_top.sv
// xor_checked_frame_extractor_top: start marker / length / xor checksum deframer
// payload held in a single-port-write, registered-read byte memory
// depends on xcfe_pkg
//
//  channel   | dir | handshake                      | content
//  ----------+-----+--------------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | raw stream byte
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | payload word, count, last, status
//  cfg       | in  | i_cfg_valid / o_cfg_ready      | start marker
//
// one stream byte per cycle while hunting, reading the length and taking payload
// checksum byte waits until the output register is free
// replay reads one byte per cycle from the memory until the current word is full,
// then waits until the word is flushed to a free output register; input is held off
// for the whole replay, which lasts longer while the output stalls
// reset is synchronous; no clearing pass, only bytes of the current frame are read
// the output register lets a finished item wait while hunting goes on

module xor_checked_frame_extractor_top #(
    parameter int unsigned BUFFER_DEPTH     = 256,
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [7:0]                   i_cfg_data,
    // byte stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
    // result words out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [xcfe_pkg::TDATA_W-1:0] m_axis_tdata,   // byte0, byte1, byte2, byte3, byte_count
    output logic                         m_axis_tlast,
    output logic [xcfe_pkg::TUSER_W-1:0] m_axis_tuser    // [0] status
);

    import xcfe_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CHUNK = (BYTES_PER_RESULT > FIELD_BYTES) ? FIELD_BYTES :
                                    (BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT;
    localparam int unsigned CAP   = (BUFFER_DEPTH < 255) ? BUFFER_DEPTH : 255;
    localparam logic [7:0]       CAP_B    = 8'(CAP);
    localparam logic [CNT_W-1:0] CHUNK_C  = CNT_W'(CHUNK);
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

    // control
    t_state               r_state, n_state;
    logic [7:0]           r_marker, n_marker;
    logic [7:0]           r_left, n_left;
    logic [7:0]           r_xor, n_xor;
    logic [7:0]           r_wr_idx, n_wr_idx;
    logic [7:0]           r_stored, n_stored;
    logic [7:0]           r_issue, n_issue;
    logic                 r_rd_pend, n_rd_pend;
    logic [CNT_W-1:0]     r_word_cnt, n_word_cnt;
    logic [RES_W-1:0]     r_res_cnt, n_res_cnt;
    logic                 r_out_valid, n_out_valid;
    // payload
    logic [7:0]           r_word [FIELD_BYTES];
    logic [7:0]           n_word [FIELD_BYTES];
    logic [TDATA_W-1:0]   r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;
    logic                 r_out_status, n_out_status;

    logic [7:0]           r_store [BUFFER_DEPTH];
    logic [7:0]           r_rd_data;

    logic                 in_acc;
    logic                 out_free;
    logic                 wr_en;
    logic                 rd_en;
    logic                 flush;
    logic                 flush_last;
    logic [7:0]           stored_now;
    logic [CNT_W:0]       in_flight;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_HUNT) || (r_state == ST_LEN) ||
                           (r_state == ST_PAYLOAD) || ((r_state == ST_CHECK) && out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = TUSER_W'(r_out_status);

    // bytes past the buffer are checked but not kept
    assign stored_now = (r_wr_idx < CAP_B) ? r_wr_idx : CAP_B;

    assign wr_en = (r_state == ST_PAYLOAD) && in_acc && (32'(r_wr_idx) < 32'(BUFFER_DEPTH));

    // replay: a word is flushed once it is full or the last byte has landed, and the output register is free
    assign in_flight  = {1'b0, r_word_cnt} + (CNT_W+1)'(r_rd_pend);
    assign rd_en      = (r_state == ST_REPLAY) && (r_issue < r_stored) &&
                        (in_flight < {1'b0, CHUNK_C});
    assign flush      = (r_state == ST_REPLAY) && !r_rd_pend && (r_word_cnt != '0) &&
                        ((r_word_cnt == CHUNK_C) || (r_issue == r_stored)) && out_free;
    assign flush_last = (r_issue == r_stored) || (r_res_cnt == RES_LAST);

    always_comb begin
        n_state      = r_state;
        n_marker     = r_marker;
        n_left       = r_left;
        n_xor        = r_xor;
        n_wr_idx     = r_wr_idx;
        n_stored     = r_stored;
        n_issue      = r_issue;
        n_rd_pend    = rd_en;
        n_word_cnt   = r_word_cnt;
        n_res_cnt    = r_res_cnt;
        n_out_valid  = r_out_valid;
        n_word       = r_word;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            n_marker = i_cfg_data;
        end

        case (r_state)
            ST_HUNT: begin
                if (in_acc && (s_axis_tdata == r_marker)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (in_acc) begin
                    if (s_axis_tdata < LEN_MIN) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_left   = (s_axis_tdata >= LEN_OVERHEAD) ?
                                   (s_axis_tdata - LEN_OVERHEAD) : 8'd0;
                        n_xor    = 8'd0;
                        n_wr_idx = 8'd0;
                        n_state  = (s_axis_tdata > LEN_OVERHEAD) ? ST_PAYLOAD : ST_CHECK;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (in_acc) begin
                    n_wr_idx = r_wr_idx + 8'd1;
                    n_xor    = r_xor ^ s_axis_tdata;
                    n_left   = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (in_acc) begin
                    n_left   = 8'd0;
                    n_xor    = 8'd0;
                    n_wr_idx = 8'd0;
                    if ((s_axis_tdata != r_xor) || (stored_now == 8'd0)) begin
                        // status-only item
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        n_out_last   = 1'b1;
                        n_out_status = (s_axis_tdata != r_xor) ? STATUS_BAD : STATUS_OK;
                        n_state      = ST_HUNT;
                    end else begin
                        n_stored   = stored_now;
                        n_issue    = 8'd0;
                        n_word_cnt = '0;
                        n_res_cnt  = '0;
                        for (int i = 0; i < FIELD_BYTES; i++) begin
                            n_word[i] = 8'd0;
                        end
                        n_state = ST_REPLAY;
                    end
                end
            end
            ST_REPLAY: begin
                if (rd_en) begin
                    n_issue = r_issue + 8'd1;
                end
                if (r_rd_pend) begin
                    n_word[r_word_cnt[1:0]] = r_rd_data;
                    n_word_cnt              = r_word_cnt + CNT_W'(1);
                end
                if (flush) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = {5'd0, r_word_cnt, r_word[3], r_word[2], r_word[1], r_word[0]};
                    n_out_last   = flush_last;
                    n_out_status = STATUS_OK;
                    n_res_cnt    = r_res_cnt + RES_W'(1);
                    n_word_cnt   = '0;
                    for (int i = 0; i < FIELD_BYTES; i++) begin
                        n_word[i] = 8'd0;
                    end
                    if (flush_last) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_marker    <= START_MARKER_RST;
            r_left      <= 8'd0;
            r_xor       <= 8'd0;
            r_wr_idx    <= 8'd0;
            r_stored    <= 8'd0;
            r_issue     <= 8'd0;
            r_rd_pend   <= 1'b0;
            r_word_cnt  <= '0;
            r_res_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_marker    <= n_marker;
            r_left      <= n_left;
            r_xor       <= n_xor;
            r_wr_idx    <= n_wr_idx;
            r_stored    <= n_stored;
            r_issue     <= n_issue;
            r_rd_pend   <= n_rd_pend;
            r_word_cnt  <= n_word_cnt;
            r_res_cnt   <= n_res_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[AW'(r_wr_idx)] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[AW'(r_issue)];
        end
    end

`ifndef SYNTHESIS
    a_pend_only_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == ST_REPLAY))
        else $error("memory read data outside replay");

    a_word_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLAY) |-> ((r_word_cnt <= CHUNK_C) && (r_issue <= r_stored)))
        else $error("replay word or read pointer overran");

    a_last_ends_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (flush && flush_last) |=> ((r_state == ST_HUNT) && r_out_valid && r_out_last))
        else $error("final item did not close the frame");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[34:32] == '0)) |-> r_out_last)
        else $error("status-only item without last");
`endif

endmodule

### tb/sv/xor_checked_frame_extractor_top_tb.sv
// xor_checked_frame_extractor_top_tb: self-checking bench for the xor checked frame extractor
// byte stream driven from a queue, result words checked against an in-bench frame predictor
// depends on xcfe_pkg and xor_checked_frame_extractor_top

module xor_checked_frame_extractor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcfe_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int STORE_DEPTH    = 256;
    localparam int WORD_BYTES     = 4;
    localparam int BYTES_W        = FIELD_BYTES * 8;
    localparam int LOG_LIMIT      = 10;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int PHASE_ITEMS    = 30;

    typedef struct {
        logic [7:0] value;
        bit         hold;
    } t_stream_item;

    typedef struct {
        logic [FIELD_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        last;
        logic                        status;
    } t_frame_word;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [7:0]           i_cfg_data    = 8'h00;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;            // byte0, byte1, byte2, byte3, byte_count
    logic                 m_axis_tlast;
    logic [TUSER_W-1:0]   m_axis_tuser;            // [0] status

    xor_checked_frame_extractor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // frame predictor state
    t_state      hunt_phase    = ST_HUNT;
    logic [7:0]  active_marker = START_MARKER_RST;
    logic [7:0]  bytes_left    = '0;
    logic [7:0]  xor_acc       = '0;
    logic [7:0]  fill_index    = '0;
    logic [7:0]  payload_copy [STORE_DEPTH];

    t_frame_word  words_due[$];
    t_stream_item stream_pending[$];

    int queued_items   = 0;
    int bytes_taken    = 0;
    int words_checked  = 0;
    int mismatches     = 0;
    int frames_ok      = 0;
    int frames_bad     = 0;
    int frames_dropped = 0;
    int markers_used   = 1;
    int idle_cycles    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit source_calm    = 1'b0;
    bit sink_calm      = 1'b0;

    function automatic int pick_wait(inout bit calm);
        // occasionally switch between back-to-back and randomly gapped stretches
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    function void emit_frame_words(bit bad);
        t_frame_word w;
        int stored;
        int pos;
        int take;
        int n;
        stored = int'(fill_index);
        pos = 0;
        n = 0;
        if (bad || stored == 0) begin
            w.bytes  = '0;
            w.count  = '0;
            w.last   = 1'b1;
            w.status = bad ? STATUS_BAD : STATUS_OK;
            words_due.push_back(w);
        end else begin
            while (pos < stored && n < MAX_RESULTS) begin
                take = stored - pos;
                if (take > WORD_BYTES) take = WORD_BYTES;
                w.bytes = '0;
                for (int j = 0; j < take; j++) w.bytes[j] = payload_copy[pos + j];
                w.count = CNT_W'(take);
                pos += take;
                n++;
                w.last   = (pos >= stored || n == MAX_RESULTS);
                w.status = STATUS_OK;
                words_due.push_back(w);
            end
        end
    endfunction

    function void take_stream_byte(logic [7:0] b);
        bit bad;
        case (hunt_phase)
            ST_HUNT: begin
                if (b == active_marker) hunt_phase = ST_LEN;
            end
            ST_LEN: begin
                if (b < LEN_MIN) begin
                    hunt_phase = ST_HUNT;
                    frames_dropped++;
                end else begin
                    if (b >= LEN_OVERHEAD) bytes_left = b - LEN_OVERHEAD;
                    else bytes_left = '0;
                    xor_acc    = '0;
                    fill_index = '0;
                    if (bytes_left != 0) hunt_phase = ST_PAYLOAD;
                    else hunt_phase = ST_CHECK;
                end
            end
            ST_PAYLOAD: begin
                payload_copy[fill_index] = b;
                fill_index = fill_index + 8'd1;
                xor_acc    = xor_acc ^ b;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 0) hunt_phase = ST_CHECK;
            end
            default: begin
                bad = (b != xor_acc);
                emit_frame_words(bad);
                if (bad) frames_bad++;
                else frames_ok++;
                hunt_phase = ST_HUNT;
                bytes_left = '0;
                xor_acc    = '0;
                fill_index = '0;
            end
        endcase
    endfunction

    function void note_mismatch(string what, t_frame_word want);
        mismatches++;
        if (mismatches <= LOG_LIMIT) begin
            $display("%0t mismatch (%s): got bytes %h count %0d last %b status %b",
                     $realtime, what, m_axis_tdata[BYTES_W-1:0],
                     m_axis_tdata[BYTES_W+CNT_W-1:BYTES_W], m_axis_tlast, m_axis_tuser[0]);
            $display("    expected bytes %h count %0d last %b status %b",
                     want.bytes, want.count, want.last, want.status);
        end
    endfunction

    // input side first so a word is predicted before any later word is checked
    always @(posedge i_clk) begin : monitor
        t_frame_word want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_stream_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (words_due.size() == 0) begin
                    want = '{bytes: '0, count: '0, last: 1'b0, status: 1'b0};
                    note_mismatch("no word due", want);
                end else begin
                    want = words_due.pop_front();
                    if (m_axis_tdata[BYTES_W-1:0] !== want.bytes
                        || m_axis_tdata[BYTES_W+CNT_W-1:BYTES_W] !== want.count
                        || m_axis_tdata[TDATA_W-1:BYTES_W+CNT_W] !== '0
                        || m_axis_tlast !== want.last
                        || m_axis_tuser[0] !== want.status)
                        note_mismatch("field", want);
                end
            end
        end
    end

    always @(posedge i_clk) begin : driver
        logic next_valid;
        logic took;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            next_valid = s_axis_tvalid && !took;
            if (took) gap_left = pick_wait(source_calm);
            else if (!s_axis_tvalid && gap_left > 0) gap_left--;
            // a held item waits until the block has delivered everything owed so far
            if (!next_valid && gap_left == 0 && stream_pending.size() != 0
                && (!stream_pending[0].hold || (!took && words_due.size() == 0))) begin
                s_axis_tdata <= stream_pending[0].value;
                void'(stream_pending.pop_front());
                next_valid = 1'b1;
            end
            s_axis_tvalid <= next_valid;
        end
    end

    always @(posedge i_clk) begin : sink
        logic next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            next_ready = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                stall_left = pick_wait(sink_calm);
                next_ready = (stall_left == 0);
            end else if (!m_axis_tready) begin
                if (stall_left > 0) stall_left--;
                next_ready = (stall_left == 0);
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t no handshake for %0d cycles, %0d words still due",
                         $realtime, IDLE_LIMIT, words_due.size());
                $display("[xor_checked_frame_extractor_top] ERROR");
                $finish;
            end
        end
    end

    function void queue_byte(logic [7:0] v, bit hold);
        stream_pending.push_back('{value: v, hold: hold});
        queued_items++;
    endfunction

    function void queue_frame(logic [7:0] marker, logic [7:0] len, bit corrupt, bit hold);
        logic [7:0] sum;
        logic [7:0] v;
        int body;
        queue_byte(marker, hold);
        queue_byte(len, 1'b0);
        if (len >= LEN_MIN) begin
            body = (len >= LEN_OVERHEAD) ? int'(len - LEN_OVERHEAD) : 0;
            sum = '0;
            for (int i = 0; i < body; i++) begin
                // a marker value inside the payload must not restart the frame
                v = ($urandom_range(0, 15) == 0) ? marker : 8'($urandom_range(0, 255));
                sum ^= v;
                queue_byte(v, 1'b0);
            end
            if (corrupt) sum ^= 8'($urandom_range(1, 255));
            queue_byte(sum, 1'b0);
        end
    endfunction

    function void queue_random_chunk(logic [7:0] marker);
        int pick;
        int noise;
        logic [7:0] len;
        logic [7:0] v;
        bit hold;
        pick = $urandom_range(0, 99);
        hold = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(15, 40));
        else len = 8'($urandom_range(2, 14));
        if (pick < 62) begin
            queue_frame(marker, len, 1'b0, hold);
        end else if (pick < 74) begin
            queue_frame(marker, len, 1'b1, hold);
        end else if (pick < 84) begin
            queue_frame(marker, 8'($urandom_range(0, 1)), 1'b0, hold);
        end else begin
            // stray bytes while hunting, never the marker itself
            noise = $urandom_range(1, 3);
            for (int i = 0; i < noise; i++) begin
                v = 8'($urandom_range(0, 255));
                if (v == marker) v = v + 8'd1;
                queue_byte(v, 1'b0);
            end
        end
    endfunction

    task automatic wait_drained();
        while (!(stream_pending.size() == 0 && !s_axis_tvalid && words_due.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_marker(logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_marker = v;
        markers_used++;
    endtask

    task automatic run_random_phase(logic [7:0] marker, int budget);
        int stop_at;
        stop_at = queued_items + budget;
        while (queued_items < stop_at) queue_random_chunk(marker);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise extremes, short lengths, empty payloads, byte extremes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_frame(START_MARKER_RST, 8'd0, 1'b0, 1'b0);
        queue_frame(START_MARKER_RST, 8'd1, 1'b0, 1'b0);
        queue_frame(START_MARKER_RST, 8'd2, 1'b0, 1'b1);
        queue_frame(START_MARKER_RST, 8'd3, 1'b1, 1'b0);
        queue_byte(START_MARKER_RST, 1'b0);
        queue_byte(8'd8, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_frame(START_MARKER_RST, 8'd7, 1'b0, 1'b0);

        run_random_phase(START_MARKER_RST, PHASE_ITEMS);
        wait_drained();

        write_marker(8'h00);
        run_random_phase(8'h00, PHASE_ITEMS);
        wait_drained();

        // top marker value, and a long frame that ends in a part word
        write_marker(8'hFF);
        run_random_phase(8'hFF, PHASE_ITEMS / 3);
        queue_frame(8'hFF, 8'd102, 1'b0, 1'b1);
        wait_drained();

        write_marker(8'($urandom_range(1, 254)));
        run_random_phase(active_marker, PHASE_ITEMS);
        wait_drained();

        if (words_due.size() != 0) begin
            $display("%0d result words never arrived", words_due.size());
            mismatches += words_due.size();
        end
        $display("stream bytes %0d, result words %0d, start marker settings %0d",
                 bytes_taken, words_checked, markers_used);
        $display("frames passed %0d, checksum failures %0d, dropped on short length %0d",
                 frames_ok, frames_bad, frames_dropped);
        if (mismatches == 0) begin
            $display("[xor_checked_frame_extractor_top] OK");
        end else begin
            $display("[xor_checked_frame_extractor_top] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/xcfe_pkg.sv
hw/rtl/xor_checked_frame_extractor_top.sv
tb/sv/xor_checked_frame_extractor_top_tb.sv
